// ===== sv/gtg_pkg.sv =====
// ============================================================================
// Go-to-goal controller package
// Shared widths, constants, register indexes and the CORDIC arctangent table.
// ============================================================================
`default_nettype none

package gtg_pkg;

   // Pipeline depth of the CORDIC and the square-root recurrence.
   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STEPS    = 15;
   localparam int PIPE_DEPTH    = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   // Datapath widths.
   localparam int XY_W   = 26;   // CORDIC x and y, offset scaled by 256 plus growth
   localparam int Z_W    = 28;   // angle accumulator, units of 2^-24 rad
   localparam int SQ_W   = 31;   // square-root remainder and partial root
   localparam int SQ_MSB = 28;   // weight of the first root bit pair

   // Angle constants.
   localparam logic signed [Z_W-1:0] ANG_PI_Q24      = Z_W'(52707179);
   localparam logic signed [Z_W-1:0] ANG_HALF_PI_Q24 = Z_W'(26353589);
   localparam logic signed [15:0]    BEARING_MAX     = 16'sd12868;
   localparam logic [15:0]           ANGULAR_MAX     = 16'd25736;

   // Register reset values.
   localparam logic [13:0] GOAL_X_RESET        = 14'd1024;
   localparam logic [13:0] GOAL_Y_RESET        = 14'd1024;
   localparam logic [11:0] SPEED_GAIN_RESET    = 12'd256;
   localparam logic [13:0] SPEED_LIMIT_RESET   = 14'd3072;
   localparam logic [13:0] ARRIVE_RADIUS_RESET = 14'd102;
   localparam logic [13:0] TURN_TOL_RESET      = 14'd819;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_GOAL_X         = 3'd0,
      REG_GOAL_Y         = 3'd1,
      REG_SPEED_GAIN     = 3'd2,
      REG_SPEED_LIMIT    = 3'd3,
      REG_ARRIVE_RADIUS  = 3'd4,
      REG_TURN_TOLERANCE = 3'd5
   } csr_index_type;

   // One slot of the CORDIC / square-root pipeline.
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic [SQ_W-1:0]        rem;
      logic [SQ_W-1:0]        root;
      logic                   stop;
      logic signed [14:0]     heading;
   } pipe_slot_type;

   // Rounded arctangent of 2^-i in units of 2^-24 rad.
   function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
      logic signed [Z_W-1:0] val;
      begin
         case (idx)
            5'd0:  val = Z_W'(13176795);
            5'd1:  val = Z_W'(7778716);
            5'd2:  val = Z_W'(4110060);
            5'd3:  val = Z_W'(2086331);
            5'd4:  val = Z_W'(1047214);
            5'd5:  val = Z_W'(524117);
            5'd6:  val = Z_W'(262123);
            5'd7:  val = Z_W'(131069);
            5'd8:  val = Z_W'(65536);
            5'd9:  val = Z_W'(32768);
            5'd10: val = Z_W'(16384);
            5'd11: val = Z_W'(8192);
            5'd12: val = Z_W'(4096);
            5'd13: val = Z_W'(2048);
            5'd14: val = Z_W'(1024);
            5'd15: val = Z_W'(512);
            5'd16: val = Z_W'(256);
            5'd17: val = Z_W'(128);
            5'd18: val = Z_W'(64);
            5'd19: val = Z_W'(32);
            5'd20: val = Z_W'(16);
            5'd21: val = Z_W'(8);
            5'd22: val = Z_W'(4);
            5'd23: val = Z_W'(2);
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/go_to_goal_velocity_controller.sv =====
// ============================================================================
// Go-to-goal velocity controller
// Turns a robot pose into a stop, turn-in-place or drive-forward command
// using a pipelined CORDIC for the bearing and a pipelined square root.
// ============================================================================
//
//   Channel   Direction  Handshake        Payload
//   req_      in         tvalid / tready  tdata: pos_x, pos_y, heading
//   rsp_      out        tvalid / tready  tdata: linear_speed, angular_speed
//   csr_      in         we only          addr, wdata (14 bits)
//
// One request is taken per cycle while the result side is not stalled; a result
// passes through P0, P1, the pipeline slots, Q1, Q2 and the output register.
// A stalled result freezes every stage; a one-entry skid buffer at the input
// keeps req_tready a register. Synchronous reset clears all valid bits and
// loads the register defaults; no clearing pass is needed.
`default_nettype none

module go_to_goal_velocity_controller
   import gtg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request: pos_x [13:0], pos_y [27:14], heading [42:28], zero fill.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // Result: linear_speed [13:0], angular_speed [28:14], zero fill.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [13:0] csr_wdata
);

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [13:0] goal_x_ff, goal_y_ff, speed_limit_ff, arrive_radius_ff, turn_tol_ff;
   logic [11:0] speed_gain_ff;
   logic [27:0] radius_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_x_ff        <= GOAL_X_RESET;
         goal_y_ff        <= GOAL_Y_RESET;
         speed_gain_ff    <= SPEED_GAIN_RESET;
         speed_limit_ff   <= SPEED_LIMIT_RESET;
         arrive_radius_ff <= ARRIVE_RADIUS_RESET;
         turn_tol_ff      <= TURN_TOL_RESET;
         radius_sq_ff     <= 28'(ARRIVE_RADIUS_RESET * ARRIVE_RADIUS_RESET);
      end else begin
         radius_sq_ff <= arrive_radius_ff * arrive_radius_ff;
         if (csr_we) begin
            case (csr_addr)
               REG_GOAL_X:         goal_x_ff        <= csr_wdata;
               REG_GOAL_Y:         goal_y_ff        <= csr_wdata;
               REG_SPEED_GAIN:     speed_gain_ff    <= csr_wdata[11:0];
               REG_SPEED_LIMIT:    speed_limit_ff   <= csr_wdata;
               REG_ARRIVE_RADIUS:  arrive_radius_ff <= csr_wdata;
               REG_TURN_TOLERANCE: turn_tol_ff      <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Global advance and input skid buffer.
   // ---------------------------------------------------------------------
   logic        rsp_valid_ff;
   logic        advance;
   logic        skid_valid_ff;
   logic [42:0] skid_data_ff;
   logic        req_fire;
   logic        src_valid;
   logic [42:0] src_data;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign src_valid  = skid_valid_ff || req_fire;
   assign src_data   = skid_valid_ff ? skid_data_ff : req_tdata[42:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !advance) begin
         skid_data_ff <= req_tdata[42:0];
      end
   end

   // ---------------------------------------------------------------------
   // Stage P0: offset to the goal.
   // ---------------------------------------------------------------------
   logic               p0_valid_ff;
   logic signed [14:0] p0_dx_ff, p0_dy_ff, p0_heading_ff;
   logic signed [14:0] dx_in, dy_in;

   assign dx_in = $signed({1'b0, goal_x_ff}) - $signed({1'b0, src_data[13:0]});
   assign dy_in = $signed({1'b0, goal_y_ff}) - $signed({1'b0, src_data[27:14]});

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (advance) begin
         p0_valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p0_dx_ff      <= dx_in;
         p0_dy_ff      <= dy_in;
         p0_heading_ff <= $signed(src_data[42:28]);
      end
   end

   // ---------------------------------------------------------------------
   // Stage P1: squares and CORDIC quadrant pre-rotation.
   // ---------------------------------------------------------------------
   logic                   p1_valid_ff;
   logic [27:0]            p1_sqx_ff, p1_sqy_ff;
   logic signed [XY_W-1:0] p1_x_ff, p1_y_ff;
   logic signed [Z_W-1:0]  p1_z_ff;
   logic signed [14:0]     p1_heading_ff;
   logic signed [29:0]     sqx_full, sqy_full;
   logic signed [XY_W-1:0] x256, y256, x_in, y_in;
   logic signed [Z_W-1:0]  z_in;

   assign sqx_full = p0_dx_ff * p0_dx_ff;
   assign sqy_full = p0_dy_ff * p0_dy_ff;
   assign x256     = {{(XY_W-23){p0_dx_ff[14]}}, p0_dx_ff, 8'd0};
   assign y256     = {{(XY_W-23){p0_dy_ff[14]}}, p0_dy_ff, 8'd0};

   // Left half plane: rotate by a quarter turn toward the x axis.
   always_comb begin
      x_in = x256;
      y_in = y256;
      z_in = '0;
      if (p0_dx_ff[14]) begin
         if (!p0_dy_ff[14]) begin
            x_in = y256;
            y_in = -x256;
            z_in = ANG_HALF_PI_Q24;
         end else begin
            x_in = -y256;
            y_in = x256;
            z_in = -ANG_HALF_PI_Q24;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= p0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_sqx_ff     <= sqx_full[27:0];
         p1_sqy_ff     <= sqy_full[27:0];
         p1_x_ff       <= x_in;
         p1_y_ff       <= y_in;
         p1_z_ff       <= z_in;
         p1_heading_ff <= p0_heading_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage P2: squared distance and arrival test; loads pipeline slot 0.
   // ---------------------------------------------------------------------
   pipe_slot_type      slot_ff [0:PIPE_DEPTH];
   logic [PIPE_DEPTH:0] slot_valid_ff;
   logic [29:0]        dsq;

   assign dsq = {2'b00, p1_sqx_ff} + {2'b00, p1_sqy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (advance) begin
         slot_valid_ff <= {slot_valid_ff[PIPE_DEPTH-1:0], p1_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_ff[0].x       <= p1_x_ff;
         slot_ff[0].y       <= p1_y_ff;
         slot_ff[0].z       <= p1_z_ff;
         slot_ff[0].rem     <= {1'b0, dsq};
         slot_ff[0].root    <= '0;
         slot_ff[0].stop    <= (dsq <= {2'b00, radius_sq_ff});
         slot_ff[0].heading <= p1_heading_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline slots: one CORDIC rotation per stage, one root bit per stage up to SQRT_STEPS.
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_slot
      pipe_slot_type slot_in;
      pipe_slot_type rot_in;

      // CORDIC vectoring step with floor shifts.
      if (k < CORDIC_STAGES) begin : g_rot
         logic signed [XY_W-1:0] xs, ys;
         always_comb begin
            xs     = slot_ff[k].x >>> k;
            ys     = slot_ff[k].y >>> k;
            rot_in = slot_ff[k];
            if (!slot_ff[k].y[XY_W-1]) begin
               rot_in.x = slot_ff[k].x + ys;
               rot_in.y = slot_ff[k].y - xs;
               rot_in.z = slot_ff[k].z + atan_q24(5'(k));
            end else begin
               rot_in.x = slot_ff[k].x - ys;
               rot_in.y = slot_ff[k].y + xs;
               rot_in.z = slot_ff[k].z - atan_q24(5'(k));
            end
         end
      end else begin : g_rot_pass
         assign rot_in = slot_ff[k];
      end

      // Digit-by-digit square root step.
      if (k < SQRT_STEPS) begin : g_sqrt
         localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (SQ_MSB - 2 * k);
         logic [SQ_W-1:0] trial;
         always_comb begin
            trial   = slot_ff[k].root + SQ_BIT;
            slot_in = rot_in;
            if (slot_ff[k].rem >= trial) begin
               slot_in.rem  = slot_ff[k].rem - trial;
               slot_in.root = (slot_ff[k].root >> 1) + SQ_BIT;
            end else begin
               slot_in.root = slot_ff[k].root >> 1;
            end
         end
      end else begin : g_sqrt_pass
         assign slot_in = rot_in;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            slot_ff[k+1] <= slot_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage Q1: bearing rounding and clamping, distance rounding.
   // ---------------------------------------------------------------------
   pipe_slot_type         last_slot;
   logic                  q1_valid_ff;
   logic signed [15:0]    q1_bearing_ff;
   logic [14:0]           q1_dist_ff;
   logic                  q1_stop_ff;
   logic signed [14:0]    q1_heading_ff;
   logic signed [Z_W-1:0] z_clamped;
   logic signed [Z_W-1:0] z_shifted;
   logic signed [15:0]    bearing_in;
   logic [14:0]           dist_in;

   assign last_slot = slot_ff[PIPE_DEPTH];

   always_comb begin
      z_clamped = last_slot.z;
      if (last_slot.z > ANG_PI_Q24) begin
         z_clamped = ANG_PI_Q24;
      end else if (last_slot.z < -ANG_PI_Q24) begin
         z_clamped = -ANG_PI_Q24;
      end
      z_shifted  = (z_clamped + Z_W'(2048)) >>> 12;
      bearing_in = z_shifted[15:0];
      if (bearing_in > BEARING_MAX) begin
         bearing_in = BEARING_MAX;
      end else if (bearing_in < -BEARING_MAX) begin
         bearing_in = -BEARING_MAX;
      end
      // Round to nearest: bump the floor root when the remainder exceeds it.
      dist_in = last_slot.root[14:0] + 15'(last_slot.rem > last_slot.root);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else if (advance) begin
         q1_valid_ff <= slot_valid_ff[PIPE_DEPTH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_bearing_ff <= bearing_in;
         q1_dist_ff    <= dist_in;
         q1_stop_ff    <= last_slot.stop;
         q1_heading_ff <= last_slot.heading;
      end
   end

   // ---------------------------------------------------------------------
   // Stage Q2: clamped absolute bearing error and gain product.
   // ---------------------------------------------------------------------
   logic               q2_valid_ff;
   logic [14:0]        q2_ang_ff;
   logic [26:0]        q2_prod_ff;
   logic               q2_stop_ff;
   logic signed [16:0] err;
   logic [16:0]        err_abs;
   logic [14:0]        ang_in;

   always_comb begin
      err     = 17'(q1_bearing_ff) - 17'(q1_heading_ff);
      err_abs = err[16] ? 17'(-err) : 17'(err);
      ang_in  = (err_abs > 17'(ANGULAR_MAX)) ? ANGULAR_MAX[14:0] : err_abs[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else if (advance) begin
         q2_valid_ff <= q1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q2_ang_ff  <= ang_in;
         q2_prod_ff <= speed_gain_ff * q1_dist_ff;
         q2_stop_ff <= q1_stop_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output register: speed rounding, limit and command selection.
   // ---------------------------------------------------------------------
   logic [13:0] rsp_linear_ff;
   logic [14:0] rsp_angular_ff;
   logic [27:0] lin_sum;
   logic [19:0] lin_raw;
   logic [13:0] lin_capped;
   logic [13:0] linear_in;
   logic [14:0] angular_in;

   always_comb begin
      lin_sum    = {1'b0, q2_prod_ff} + 28'd128;
      lin_raw    = lin_sum[27:8];
      lin_capped = (lin_raw > {6'd0, speed_limit_ff}) ? speed_limit_ff : lin_raw[13:0];
      linear_in  = '0;
      angular_in = '0;
      if (!q2_stop_ff) begin
         if (q2_ang_ff > {1'b0, turn_tol_ff}) begin
            angular_in = q2_ang_ff;
         end else begin
            linear_in = lin_capped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= q2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_linear_ff  <= linear_in;
         rsp_angular_ff <= angular_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_angular_ff, rsp_linear_ff};

endmodule

`default_nettype wire

// ===== sim/go_to_goal_velocity_controller_test.sv =====
// ----------------------------------------------------------------------------
// Go-to-goal velocity controller testbench
// Streams robot poses into the controller and checks every stop, turn or
// drive command against a bit-exact predictor kept in this file. Directed
// tests cover the default goal, register extremes and write masking. A
// random run then sweeps several register settings while both stream sides
// idle and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_goal_velocity_controller_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gtg_pkg::*;

   // Pipeline depth from request to result, and a watchdog limit.
   localparam int PIPE_LATENCY = PIPE_DEPTH + 6;
   localparam int CYCLE_LIMIT  = 200000;

   // Register indexes that map to nothing.
   localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

   // Angle constants in units of 2^-24 rad, and output limits.
   localparam longint HALF_TURN_Q24    = 52707179;
   localparam longint QUARTER_TURN_Q24 = 26353589;
   localparam int     BEARING_LIMIT    = 12868;
   localparam int     TURN_RATE_LIMIT  = 25736;

   // Arctangent of 2^-i in units of 2^-24 rad, rounded.
   localparam longint ARCTAN_Q24 [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct packed {
      logic signed [14:0] heading;
      logic [13:0]        pos_y;
      logic [13:0]        pos_x;
   } pose_type;

   typedef struct packed {
      logic [14:0] angular_speed;
      logic [13:0] linear_speed;
   } command_type;

   typedef enum {
      STALL_NONE,
      STALL_RANDOM,
      STALL_SPARSE,
      STALL_PERIODIC
   } stall_mode_type;

   // DUT connections, all inputs known from time zero.
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // Request: pos_x [13:0], pos_y [27:14], heading [42:28], zero fill.
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // Result: linear_speed [13:0], angular_speed [28:14], zero fill.
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [13:0] csr_wdata  = '0;

   // Shadow copy of the configuration registers.
   logic [13:0] goal_x_q         = GOAL_X_RESET;
   logic [13:0] goal_y_q         = GOAL_Y_RESET;
   logic [11:0] speed_gain_q     = SPEED_GAIN_RESET;
   logic [13:0] speed_limit_q    = SPEED_LIMIT_RESET;
   logic [13:0] arrive_radius_q  = ARRIVE_RADIUS_RESET;
   logic [13:0] turn_tolerance_q = TURN_TOL_RESET;

   command_type    expected_commands[$];
   int             error_count = 0;
   int             burst_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_left  = 0;
   int unsigned    beat_count  = 0;

   go_to_goal_velocity_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: a run that hangs ends as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Bearing of the goal offset in units of 1/4096 rad, by CORDIC vectoring.
   function automatic int bearing_of(input int dx, input int dy);
      longint x, y, z, t, xs, ys;
      if (dx == 0 && dy == 0)
         return 0;
      x = longint'(dx) * 256;
      y = longint'(dy) * 256;
      z = 0;
      // Fold the left half plane into the right one by a quarter turn.
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN_Q24;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN_Q24;
         end
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_Q24[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_Q24[i];
         end
      end
      if (z > HALF_TURN_Q24)
         z = HALF_TURN_Q24;
      if (z < -HALF_TURN_Q24)
         z = -HALF_TURN_Q24;
      z = (z + 2048) >>> 12;
      if (z > BEARING_LIMIT)
         z = BEARING_LIMIT;
      if (z < -BEARING_LIMIT)
         z = -BEARING_LIMIT;
      return int'(z);
   endfunction

   // Square root rounded to the nearest integer.
   function automatic longint rounded_root(input longint v);
      longint r, c;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
         c = r | (longint'(1) << b);
         if (c * c <= v)
            r = c;
      end
      if (v - r * r > r)
         r = r + 1;
      return r;
   endfunction

   // Command expected for one pose under the current registers.
   function automatic command_type predict_command(input pose_type p);
      command_type cmd;
      int          dx, dy;
      longint      dsq, rsq, err, lin;
      cmd = '0;
      dx  = int'(goal_x_q) - int'(p.pos_x);
      dy  = int'(goal_y_q) - int'(p.pos_y);
      dsq = longint'(dx) * dx + longint'(dy) * dy;
      rsq = longint'(arrive_radius_q) * longint'(arrive_radius_q);
      if (dsq > rsq) begin
         err = longint'(bearing_of(dx, dy)) - longint'(p.heading);
         if (err < 0)
            err = -err;
         if (err > TURN_RATE_LIMIT)
            err = TURN_RATE_LIMIT;
         if (err > longint'(turn_tolerance_q)) begin
            cmd.angular_speed = err[14:0];
         end else begin
            lin = (longint'(speed_gain_q) * rounded_root(dsq) + 128) >>> 8;
            if (lin > longint'(speed_limit_q))
               lin = longint'(speed_limit_q);
            cmd.linear_speed = lin[13:0];
         end
      end
      return cmd;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic pose_type pose_of(input int x, input int y, input int h);
      pose_type p;
      p.pos_x   = x[13:0];
      p.pos_y   = y[13:0];
      p.heading = h[14:0];
      return p;
   endfunction

   function automatic int clamp_position(input int v);
      if (v < 0)
         return 0;
      if (v > 16383)
         return 16383;
      return v;
   endfunction

   // One random pose, mostly shaped so that every command kind comes up.
   function automatic pose_type random_pose();
      int kind, x, y, span, h;
      kind = $urandom_range(0, 19);
      x    = $urandom_range(0, 16383);
      y    = $urandom_range(0, 16383);
      h    = int'($urandom_range(0, 2 * BEARING_LIMIT)) - BEARING_LIMIT;
      if (kind < 7) begin
         // Any pose; now and then a heading outside the legal range.
         if ($urandom_range(0, 4) == 0)
            h = int'($urandom_range(0, 32767)) - 16384;
      end else if (kind < 14) begin
         // Heading close to the bearing, so the robot mostly drives.
         span = (turn_tolerance_q > 1996) ? 2000 : int'(turn_tolerance_q) + 4;
         h = bearing_of(int'(goal_x_q) - x, int'(goal_y_q) - y)
             + int'($urandom_range(0, 2 * span)) - span;
      end else if (kind < 19) begin
         // Near the goal, around the arrival radius.
         span = (arrive_radius_q > 1992) ? 2000 : int'(arrive_radius_q) + 8;
         x = clamp_position(int'(goal_x_q) + int'($urandom_range(0, 2 * span)) - span);
         y = clamp_position(int'(goal_y_q) + int'($urandom_range(0, 2 * span)) - span);
      end else begin
         x = int'(goal_x_q);
         y = int'(goal_y_q);
      end
      return pose_of(x, y, h);
   endfunction

   // Random register value with the extremes weighted up.
   function automatic int pick_value(input int top, input int usual);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, usual);
      endcase
   endfunction

   // Send one request; the sender works in bursts, mostly with gaps between them.
   task automatic send_pose(input pose_type p);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
      expected_commands.push_back(predict_command(p));
   endtask

   // Stop sending and wait until every expected command has come out.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_commands.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register; only called while the pipeline is empty.
   task automatic write_register(input logic [2:0] addr, input logic [13:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         REG_GOAL_X:         goal_x_q         = value;
         REG_GOAL_Y:         goal_y_q         = value;
         REG_SPEED_GAIN:     speed_gain_q     = value[11:0];
         REG_SPEED_LIMIT:    speed_limit_q    = value;
         REG_ARRIVE_RADIUS:  arrive_radius_q  = value;
         REG_TURN_TOLERANCE: turn_tolerance_q = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input int gx, input int gy, input int gain,
                            input int limit, input int radius, input int tol);
      write_register(REG_GOAL_X, gx[13:0]);
      write_register(REG_GOAL_Y, gy[13:0]);
      write_register(REG_SPEED_GAIN, gain[13:0]);
      write_register(REG_SPEED_LIMIT, limit[13:0]);
      write_register(REG_ARRIVE_RADIUS, radius[13:0]);
      write_register(REG_TURN_TOLERANCE, tol[13:0]);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset defaults: goal at (1024, 1024), each command kind, each axis direction and three quadrants.
   task automatic test_reset_defaults();
      send_pose(pose_of(1024, 1024, 0));            // zero offset
      send_pose(pose_of(1096, 1096, 0));            // just inside the radius
      send_pose(pose_of(1097, 1096, 0));            // just outside the radius
      send_pose(pose_of(0, 0, 0));                  // turn toward the goal
      send_pose(pose_of(0, 0, 3217));               // aligned, drive
      send_pose(pose_of(16383, 16383, -16384));     // most negative heading
      send_pose(pose_of(16383, 0, 16383));          // most positive heading
      send_pose(pose_of(2000, 1024, 0));            // goal straight behind
      send_pose(pose_of(1024, 0, 0));               // goal straight up
      send_pose(pose_of(1024, 16383, -6434));       // straight down, capped speed
      send_pose(pose_of(0, 1024, 0));               // goal straight ahead
      drain_results();
   endtask

   // Register extremes, width masking and unmapped indexes.
   task automatic test_register_writes();
      // Gain write with bits above its width; large limit.
      write_register(REG_SPEED_GAIN, 14'h3FFF);
      write_register(REG_SPEED_LIMIT, 14'h3FFF);
      send_pose(pose_of(0, 1024, 0));
      send_pose(pose_of(16383, 1024, BEARING_LIMIT));
      drain_results();

      // Everything at zero: an exact stop and a full reverse turn.
      write_all(0, 0, 0, 0, 0, 0);
      send_pose(pose_of(0, 0, 0));
      send_pose(pose_of(1, 0, -BEARING_LIMIT));
      send_pose(pose_of(0, 5, 6434));
      drain_results();

      // Writes to unmapped indexes change nothing.
      write_register(REG_UNMAPPED_LO, 14'h3FFF);
      write_register(REG_UNMAPPED_HI, 14'h3FFF);
      send_pose(pose_of(0, 1, 6434));
      drain_results();

      // Everything at its top.
      write_all(16383, 16383, 4095, 16383, 16383, 16383);
      send_pose(pose_of(0, 0, 0));
      send_pose(pose_of(16383, 0, 0));
      send_pose(pose_of(0, 0, -16384));
      drain_results();
   endtask

   // Random traffic over several register settings.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_all(int'(GOAL_X_RESET), int'(GOAL_Y_RESET), int'(SPEED_GAIN_RESET),
                         int'(SPEED_LIMIT_RESET), int'(ARRIVE_RADIUS_RESET),
                         int'(TURN_TOL_RESET));
            1: write_all(0, 0, 4095, 16383, 0, 0);
            2: write_all(16383, 16383, 1, 16383, 16383, 16383);
            default: write_all(pick_value(16383, 16383), pick_value(16383, 16383),
                               pick_value(16383, 4095), pick_value(16383, 16383),
                               pick_value(16383, 1500), pick_value(16383, 4000));
         endcase
         for (int n = 0; n < 118; n++) begin
            // Hold off once mid-stream until the pipeline has emptied.
            if (phase == 4 && n == 60)
               drain_results();
            send_pose(random_pose());
         end
         drain_results();
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking and receiver stalls
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      command_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_commands.size() == 0) begin
            error_count++;
            $error("unexpected result: rsp_tdata %h", rsp_tdata);
         end else begin
            want = expected_commands.pop_front();
            if (rsp_tdata[13:0] !== want.linear_speed) begin
               error_count++;
               $error("linear_speed: expected %0d, actual %0d",
                      want.linear_speed, rsp_tdata[13:0]);
            end
            if (rsp_tdata[28:14] !== want.angular_speed) begin
               error_count++;
               $error("angular_speed: expected %0d, actual %0d",
                      want.angular_speed, rsp_tdata[28:14]);
            end
         end
      end

      // The receiver switches among stall patterns every so often.
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 200);
      end else begin
         stall_left--;
      end
      beat_count++;
      case (stall_mode)
         STALL_NONE:     rsp_tready <= 1'b1;
         STALL_RANDOM:   rsp_tready <= ($urandom_range(0, 1) == 1);
         STALL_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         STALL_PERIODIC: rsp_tready <= (beat_count[2:0] < 3'd3);
         default:        rsp_tready <= 1'b1;
      endcase
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_writes();
      test_random_traffic();

      // Let any stray command surface before the verdict.
      drain_results();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== go_to_goal_velocity_controller.f =====
sv/gtg_pkg.sv
sv/go_to_goal_velocity_controller.sv
sim/go_to_goal_velocity_controller_test.sv
